// ----- design/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash words, round functions and shared types.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned QueueDep  = 4;
    localparam int unsigned QueueAw   = 2;

    localparam logic [31:0] PadWord   = 32'h8000_0000;

    // Word handed from the front end to the compression engine.
    typedef struct packed {
        logic [31:0] word;
        logic        blk_end;   // sixteenth word of a block
        logic        msg_end;   // final word of the padded message
    } t_req;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- design/sha256_digest_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest top level
// After a last word come 2 to 18 padding words; each block then takes 16 loads,
//   64 rounds and one fold, and each message ends with eight digest words.
// The single shared round unit, at one round a cycle, limits throughput; the
//   core takes no new words while its rounds run.
// Reset: synchronous active low; clears counts and restores the initial hash.
// ----------------------------------------------------------------------------
module sha256_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);

    // Front end: turns each request into one schedule word, adds padding.
    logic             f_valid, f_ready, c_valid, c_ready;
    sha256_pkg::t_req f_req, c_req;

    sha256_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_word, .i_valid_bytes,
        .i_last, .o_req_valid(f_valid), .i_req_ready(f_ready), .o_req(f_req)
    );

    // Queue lets the front keep taking requests while rounds run.
    sha256_queue u_queue (
        .i_clk, .i_rst_n, .i_wr_valid(f_valid), .o_wr_ready(f_ready),
        .i_wr_data(f_req), .o_rd_valid(c_valid), .i_rd_ready(c_ready),
        .o_rd_data(c_req)
    );

    // Back end: one round per cycle, digest held until taken.
    sha256_core u_core (
        .i_clk, .i_rst_n, .i_req_valid(c_valid), .o_req_ready(c_ready),
        .i_req(c_req), .o_valid, .i_ready, .o_digest_word, .o_word_index,
        .o_digest_last
    );

endmodule

// ----- design/sha256_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message words, counts bytes and generates padding and length words.
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_data_word,
    input  logic [2:0]          i_valid_bytes,
    input  logic                i_last,
    output logic                o_req_valid,
    input  logic                i_req_ready,
    output sha256_pkg::t_req    o_req
);

    typedef enum logic [1:0] {
        ST_TAKE,    // take message words
        ST_PAD80,   // emit the 0x80 word after a full last word
        ST_ZERO,    // zero fill up to word 14
        ST_LEN      // two length words
    } t_state;

    t_state       r_state;
    logic [60:0]  r_bytes;
    logic [3:0]   r_fill;
    logic         r_len_lo;

    logic [2:0]   cnt;
    logic [60:0]  bytes_sum;
    logic [63:0]  bits;
    logic [31:0]  word;
    logic         push;

    always_comb begin
        cnt = (!i_last || i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        bytes_sum = r_bytes + 61'(cnt);
        bits = {r_bytes, 3'b000};
        word = 32'h0;
        case (r_state)
            ST_TAKE: begin
                case (cnt)
                    3'd0:    word = sha256_pkg::PadWord;
                    3'd1:    word = {i_data_word[31:24], 24'h800000};
                    3'd2:    word = {i_data_word[31:16], 16'h8000};
                    3'd3:    word = {i_data_word[31:8], 8'h80};
                    default: word = i_data_word;
                endcase
            end
            ST_PAD80: word = sha256_pkg::PadWord;
            ST_ZERO:  word = 32'h0;
            ST_LEN:   word = r_len_lo ? bits[31:0] : bits[63:32];
            default:  word = 32'h0;
        endcase
        o_ready           = (r_state == ST_TAKE) && i_req_ready;
        o_req_valid       = (r_state == ST_TAKE) ? i_valid : 1'b1;
        o_req.word        = word;
        o_req.blk_end     = (r_fill == 4'd15);
        o_req.msg_end     = (r_state == ST_LEN) && r_len_lo;
        push              = o_req_valid && i_req_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_TAKE;
            r_bytes  <= '0;
            r_fill   <= '0;
            r_len_lo <= 1'b0;
        end else if (push) begin
            r_fill <= r_fill + 4'd1;
            case (r_state)
                ST_TAKE: begin
                    r_bytes <= bytes_sum;
                    if (i_last) begin
                        if (cnt == 3'd4)           r_state <= ST_PAD80;
                        else if (r_fill == 4'd13)  r_state <= ST_LEN;
                        else                       r_state <= ST_ZERO;
                    end
                end
                ST_PAD80: r_state <= (r_fill == 4'd13) ? ST_LEN : ST_ZERO;
                ST_ZERO:  if (r_fill == 4'd13) r_state <= ST_LEN;
                ST_LEN: begin
                    r_len_lo <= !r_len_lo;
                    if (r_len_lo) begin
                        r_state <= ST_TAKE;
                        r_bytes <= '0;
                        r_fill  <= '0;
                    end
                end
                default: r_state <= ST_TAKE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && o_req.msg_end) |-> (r_fill == 4'd15))
        else $error("message end not on a block boundary");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_fill == 4'd14 || r_fill == 4'd15))
        else $error("length words misplaced");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |-> push)
        else $error("accepted word not pushed");

endmodule

// ----- design/sha256_queue.sv -----
// ----------------------------------------------------------------------------
// SHA-256 request queue
// Small FIFO between the front end and the compression engine.
// ----------------------------------------------------------------------------
module sha256_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    output logic                o_wr_ready,
    input  sha256_pkg::t_req    i_wr_data,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output sha256_pkg::t_req    o_rd_data
);

    sha256_pkg::t_req r_mem [sha256_pkg::QueueDep];
    logic [sha256_pkg::QueueAw-1:0] r_wp, r_rp;
    logic [sha256_pkg::QueueAw:0]   r_cnt;
    logic wr, rd;

    assign o_wr_ready = (r_cnt != 3'(sha256_pkg::QueueDep));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end

endmodule

// ----- design/sha256_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Loads schedule words, runs 64 rounds per block, streams the digest out.
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  sha256_pkg::t_req    i_req,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_digest_last
);

    typedef enum logic [1:0] {
        ST_LOAD,    // collect sixteen words
        ST_ROUND,   // 64 rounds
        ST_FOLD,    // add working variables into chain
        ST_OUT      // emit eight digest words
    } t_state;

    t_state       r_state;
    logic [31:0]  r_w [16];
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [3:0]   r_wi;
    logic [5:0]   r_rnd;
    logic         r_msg_end;
    logic [2:0]   r_oi;

    logic [31:0]  w, t1, t2, ch, mj;
    logic [3:0]   ti;

    always_comb begin
        ti = r_rnd[3:0];
        if (r_rnd < 6'd16)
            w = r_w[ti];
        else
            w = r_w[ti] + sha256_pkg::sig0(r_w[ti + 4'd1]) + r_w[ti + 4'd9]
                + sha256_pkg::sig1(r_w[ti + 4'd14]);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + sha256_pkg::ssig1(r_v[4]) + ch + sha256_pkg::round_k(r_rnd) + w;
        t2 = sha256_pkg::ssig0(r_v[0]) + mj;
    end

    assign o_req_ready   = (r_state == ST_LOAD);
    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_digest_last = (r_oi == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_wi      <= '0;
            r_rnd     <= '0;
            r_oi      <= '0;
            r_msg_end <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_hash(3'(i));
        end else begin
            case (r_state)
                ST_LOAD: if (i_req_valid) begin
                    r_w[r_wi] <= i_req.word;
                    r_wi      <= r_wi + 4'd1;
                    if (i_req.blk_end) begin
                        r_msg_end <= i_req.msg_end;
                        r_rnd     <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_state   <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_w[ti] <= w;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oi    <= '0;
                    r_state <= r_msg_end ? ST_OUT : ST_LOAD;
                end
                ST_OUT: if (i_ready) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        for (int i = 0; i < 8; i++)
                            r_h[i] <= sha256_pkg::init_hash(3'(i));
                        r_state <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == 6'd63) |=> (r_state == ST_FOLD))
        else $error("round count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_wi == 4'd0))
        else $error("block started before sixteen words");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_digest_last) |=> (r_state == ST_LOAD))
        else $error("digest did not end");

endmodule

// ----- test/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels, hashes each accepted message with its own SHA-256
// model and compares every digest word with the oldest expected word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_digest_word,
    input  logic [2:0]  i_word_index,
    input  logic        i_digest_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0]  hash_state [8];
    logic [31:0]  block_words [16];
    logic [60:0]  byte_total;
    int           fill;
    t_digest_word digest_queue [$];
    int           fail_count;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] v [8];
        logic [31:0] w [64];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++) w[i] = block_words[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    task automatic append_word(input logic [31:0] w);
        block_words[fill] = w;
        fill++;
        if (fill == 16) begin
            fill = 0;
            compress();
        end
    endtask

    // Absorb one request; pad and emit the digest on the last word.
    task automatic absorb_request(input logic [31:0] w, input logic [2:0] n, input logic l);
        logic [2:0]  cnt;
        logic [63:0] bit_len;
        cnt = (!l || n > 3'd4) ? 3'd4 : n;
        byte_total += cnt;
        if (!l) begin
            append_word(w);
            return;
        end
        case (cnt)
            3'd0: append_word(32'h8000_0000);
            3'd1: append_word({w[31:24], 24'h80_0000});
            3'd2: append_word({w[31:16], 16'h8000});
            3'd3: append_word({w[31:8], 8'h80});
            default: begin
                append_word(w);
                append_word(32'h8000_0000);
            end
        endcase
        while (fill != 14) append_word(32'h0);
        bit_len = {byte_total, 3'b000};
        append_word(bit_len[63:32]);
        append_word(bit_len[31:0]);
        for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
        hash_state = StartHash;
        byte_total = '0;
        fill = 0;
    endtask

    initial begin
        hash_state = StartHash;
        byte_total = '0;
        fill = 0;
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (digest_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected digest word %h idx %0d",
                                 i_digest_word, i_word_index);
                end else begin
                    exp_w = digest_queue.pop_front();
                    if (exp_w != {i_digest_word, i_word_index, i_digest_last}) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                     exp_w.word, exp_w.index, exp_w.last,
                                     i_digest_word, i_word_index, i_digest_last);
                    end
                end
            end
            if (i_valid && i_ready_in)
                absorb_request(i_data_word, i_valid_bytes, i_last);
        end
    end

    assign o_fail_count = fail_count;
    assign o_pending    = digest_queue.size();

endmodule

// ----- test/sha256_digest_top_tb.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest testbench
// Feeds directed and random messages through the block with random idling on
// both sides, a long receiver hold-off and a drain pause; the checker does
// the hashing and comparing, this module gives the verdict.
// ----------------------------------------------------------------------------
module sha256_digest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_valid_bytes = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm_phase = 1'b0;   // no idling in the closing stretch
    bit hold_off   = 1'b0;   // long receiver stall request

    always #2 i_clk = ~i_clk;

    sha256_digest_top dut (.*);

    sha256_digest_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_data_word,
        .i_valid_bytes, .i_last, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_digest_word(o_digest_word), .i_word_index(o_word_index),
        .i_digest_last(o_digest_last), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Abort on a runaway run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, long hold-off on request, none when calm.
    initial begin
        int stall_len;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                stall_len = $urandom_range(1, 9);
                i_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until accepted; idle at random first.
    task automatic send_request(input logic [31:0] w, input logic [2:0] n, input logic l);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_word   <= w;
        i_valid_bytes <= n;
        i_last        <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send a message of given length in bytes, random content.
    task automatic send_message(input int n_bytes, input int short_mode);
        int left;
        left = n_bytes;
        while (left > 4 || (left == 4 && $urandom_range(0, 1) == 0)) begin
            // short_mode: non-last words with a short or oversized count
            send_request($urandom(),
                         short_mode ? 3'($urandom_range(0, 7)) : 3'd4, 1'b0);
            left -= 4;
        end
        send_request($urandom(), left == 4 && $urandom_range(0, 3) == 0
                     ? 3'($urandom_range(5, 7)) : 3'(left), 1'b1);
    endtask

    initial begin
        int items;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, all-ones and all-zeros words, every short
        // count, full last word, oversized counts and 55/56/64 byte borders.
        send_request(32'h0, 3'd0, 1'b1);
        send_request(32'hffff_ffff, 3'd7, 1'b1);
        send_request(32'h6162_6300, 3'd3, 1'b1);
        send_request(32'hffff_ffff, 3'd1, 1'b1);
        send_request(32'hffff_ffff, 3'd2, 1'b1);
        send_request(32'h0, 3'd5, 1'b1);
        send_request(32'hffff_ffff, 3'd1, 1'b0);
        send_request(32'h1234_5678, 3'd6, 1'b0);
        send_request(32'hdead_beef, 3'd4, 1'b1);
        send_message(55, 0);
        send_message(56, 0);
        send_message(64, 0);

        // Drain pause: hold input until every digest word has come.
        idle_input();
        while (pending != 0) @(posedge i_clk);

        // Long receiver hold-off while messages keep coming.
        hold_off = 1'b1;
        send_message(8, 0);
        send_message(12, 0);
        send_message(4, 0);
        send_message(20, 1);

        // Random messages; mostly short, a few spanning several blocks.
        items = 0;
        while (items < 300) begin
            if (items > 240) calm_phase = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                send_message($urandom_range(60, 140), $urandom_range(0, 1));
                items += 25;
            end else begin
                send_message($urandom_range(0, 40), $urandom_range(0, 3) == 0);
                items += 6;
            end
        end
        idle_input();

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sha256_digest_top.f -----
design/sha256_pkg.sv
design/sha256_front.sv
design/sha256_queue.sv
design/sha256_core.sv
design/sha256_digest_top.sv
test/sha256_digest_checker.sv
test/sha256_digest_top_tb.sv
